// ----- hdl/drxc_pkg.sv -----
package drxc_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CFG_WIDTH  = 16;
    localparam int SLOT_WIDTH = 16;
    localparam int OUT_WIDTH  = 32;
    localparam int ADDR_WIDTH = 4;

    localparam logic [CFG_WIDTH-1:0] CYCLE_LENGTH_RST      = 16'd640;
    localparam logic [CFG_WIDTH-1:0] ON_DURATION_RST       = 16'd16;
    localparam logic [CFG_WIDTH-1:0] INACTIVITY_LENGTH_RST = 16'd160;

    typedef enum logic [1:0] {
        REG_CYCLE_LENGTH      = 2'd0,
        REG_ON_DURATION       = 2'd1,
        REG_INACTIVITY_LENGTH = 2'd2,
        REG_NONE              = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] cycle_length;
        logic [CFG_WIDTH-1:0] on_duration;
        logic [CFG_WIDTH-1:0] inactivity_length;
    } t_cfg;

    typedef struct packed {
        logic                  active;
        logic [SLOT_WIDTH-1:0] slot_index;
        logic                  cycle_end;
        logic                  sleep_start;
        logic [OUT_WIDTH-1:0]  sleep_slots;
        logic [OUT_WIDTH-1:0]  sleep_periods;
    } t_result;

endpackage

// ----- hdl/drxc_slot_core.sv -----
module drxc_slot_core #(
    parameter int TIMER_WIDTH = drxc_pkg::TIMER_WIDTH_DEF,
    parameter int COUNT_WIDTH = drxc_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_ul,
    input  logic             i_dl,
    input  drxc_pkg::t_cfg   i_cfg,
    output drxc_pkg::t_result o_result
);

    logic [drxc_pkg::SLOT_WIDTH-1:0] r_slot, n_slot;
    logic [TIMER_WIDTH-1:0]          r_on, n_on;
    logic [TIMER_WIDTH-1:0]          r_inact, n_inact;
    logic                            r_dlbuf, n_dlbuf;
    logic                            r_awake, n_awake;
    logic                            r_awake_before, n_awake_before;
    logic [COUNT_WIDTH-1:0]          r_sleep_slots, n_sleep_slots;
    logic [COUNT_WIDTH-1:0]          r_sleep_periods, n_sleep_periods;

    logic [TIMER_WIDTH-1:0]          on_reload;
    logic [TIMER_WIDTH-1:0]          inact_reload;
    logic [drxc_pkg::SLOT_WIDTH:0]   len;
    logic                            first_slot;
    logic                            on_exp;
    logic                            inact_exp;
    logic                            last;
    logic                            start;

    assign on_reload    = TIMER_WIDTH'(i_cfg.on_duration);
    assign inact_reload = TIMER_WIDTH'(i_cfg.inactivity_length);

    always_comb begin
        first_slot = (r_slot == '0);
        n_on       = first_slot ? on_reload : r_on;
        n_awake    = first_slot ? 1'b1 : r_awake;
        n_inact    = (first_slot && r_dlbuf) ? inact_reload : r_inact;
        n_dlbuf    = first_slot ? 1'b0 : r_dlbuf;

        on_exp    = (n_on == TIMER_WIDTH'(1));
        inact_exp = (n_inact == TIMER_WIDTH'(1));
        if (n_on != '0) begin
            n_on = n_on - TIMER_WIDTH'(1);
        end
        if (n_inact != '0) begin
            n_inact = n_inact - TIMER_WIDTH'(1);
        end
        if ((on_exp || inact_exp) && n_on == '0 && n_inact == '0) begin
            n_awake = 1'b0;
        end

        if (i_ul) begin
            if (!n_awake) begin
                n_awake = 1'b1;
                n_dlbuf = 1'b0;
            end
            n_inact = inact_reload;
        end
        if (i_dl) begin
            if (n_awake) begin
                n_inact = inact_reload;
            end else begin
                n_dlbuf = 1'b1;
            end
        end

        start           = 1'b0;
        n_awake_before  = r_awake_before;
        n_sleep_slots   = r_sleep_slots;
        n_sleep_periods = r_sleep_periods;
        if (n_awake) begin
            n_awake_before = 1'b1;
        end else begin
            if (r_sleep_slots != '1) begin
                n_sleep_slots = r_sleep_slots + COUNT_WIDTH'(1);
            end
            if (r_awake_before) begin
                if (r_sleep_periods != '1) begin
                    n_sleep_periods = r_sleep_periods + COUNT_WIDTH'(1);
                end
                start          = 1'b1;
                n_awake_before = 1'b0;
            end
        end

        len    = (i_cfg.cycle_length == '0) ? 17'd1 : {1'b0, i_cfg.cycle_length};
        last   = (({1'b0, r_slot} + 17'd1) >= len);
        n_slot = last ? '0 : r_slot + 16'd1;

        o_result.active        = n_awake;
        o_result.slot_index    = r_slot;
        o_result.cycle_end     = last;
        o_result.sleep_start   = start;
        o_result.sleep_slots   = drxc_pkg::OUT_WIDTH'(n_sleep_slots);
        o_result.sleep_periods = drxc_pkg::OUT_WIDTH'(n_sleep_periods);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot          <= '0;
            r_on            <= '0;
            r_inact         <= '0;
            r_dlbuf         <= 1'b0;
            r_awake         <= 1'b1;
            r_awake_before  <= 1'b1;
            r_sleep_slots   <= '0;
            r_sleep_periods <= '0;
        end else if (i_step) begin
            r_slot          <= n_slot;
            r_on            <= n_on;
            r_inact         <= n_inact;
            r_dlbuf         <= n_dlbuf;
            r_awake         <= n_awake;
            r_awake_before  <= n_awake_before;
            r_sleep_slots   <= n_sleep_slots;
            r_sleep_periods <= n_sleep_periods;
        end
    end

endmodule

// ----- hdl/drx_activity_controller.sv -----
// A result is registered into the output buffer when its item is accepted and is shown once earlier results are taken.
// Throughput: one item per clock while the output buffer has room; the slot state updates in a single pass.
// A two-entry output buffer keeps input ready high while one result waits.
// Reset (synchronous, active low) clears the slot state, timers, totals and
// buffer, and restores the registers to their default values.
module drx_activity_controller #(
    parameter int TIMER_WIDTH = drxc_pkg::TIMER_WIDTH_DEF,
    parameter int COUNT_WIDTH = drxc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_ul_arrival,
    input  logic                             i_dl_arrival,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_active,
    output logic [drxc_pkg::SLOT_WIDTH-1:0]  o_slot_index,
    output logic                             o_cycle_end,
    output logic                             o_sleep_start,
    output logic [drxc_pkg::OUT_WIDTH-1:0]   o_sleep_slots,
    output logic [drxc_pkg::OUT_WIDTH-1:0]   o_sleep_periods,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [drxc_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    drxc_pkg::t_cfg    r_cfg;
    drxc_pkg::t_result res;
    drxc_pkg::t_result r_buf0, r_buf1;
    logic [1:0]        r_cnt;
    drxc_pkg::t_reg_idx reg_idx;
    logic              push;
    logic              pop;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = drxc_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx)
            drxc_pkg::REG_CYCLE_LENGTH:      prdata = 32'(r_cfg.cycle_length);
            drxc_pkg::REG_ON_DURATION:       prdata = 32'(r_cfg.on_duration);
            drxc_pkg::REG_INACTIVITY_LENGTH: prdata = 32'(r_cfg.inactivity_length);
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cycle_length      <= drxc_pkg::CYCLE_LENGTH_RST;
            r_cfg.on_duration       <= drxc_pkg::ON_DURATION_RST;
            r_cfg.inactivity_length <= drxc_pkg::INACTIVITY_LENGTH_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                drxc_pkg::REG_CYCLE_LENGTH:      r_cfg.cycle_length      <= pwdata[15:0];
                drxc_pkg::REG_ON_DURATION:       r_cfg.on_duration       <= pwdata[15:0];
                drxc_pkg::REG_INACTIVITY_LENGTH: r_cfg.inactivity_length <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    drxc_slot_core #(
        .TIMER_WIDTH(TIMER_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (push),
        .i_ul     (i_ul_arrival),
        .i_dl     (i_dl_arrival),
        .i_cfg    (r_cfg),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && !pop) begin
            if (r_cnt == 2'd0) begin
                r_buf0 <= res;
            end else begin
                r_buf1 <= res;
            end
        end else if (pop && !push) begin
            r_buf0 <= r_buf1;
        end else if (push && pop) begin
            if (r_cnt == 2'd1) begin
                r_buf0 <= res;
            end else begin
                r_buf0 <= r_buf1;
                r_buf1 <= res;
            end
        end
    end

    assign o_active        = r_buf0.active;
    assign o_slot_index    = r_buf0.slot_index;
    assign o_cycle_end     = r_buf0.cycle_end;
    assign o_sleep_start   = r_buf0.sleep_start;
    assign o_sleep_slots   = r_buf0.sleep_slots;
    assign o_sleep_periods = r_buf0.sleep_periods;

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && r_cnt == 2'd0 |=> o_out_valid)
        else $error("accepted item did not reach the output");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push && r_cnt == 2'd1 |=> !o_out_valid)
        else $error("output buffer did not drain");

    a_sleep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && res.sleep_start |-> !res.active && res.sleep_slots != '0)
        else $error("sleep period began while awake");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |=> r_cnt != 2'd3)
        else $error("output buffer overflow");

endmodule
